[rtl/afd_pkg.sv]
`timescale 1ns / 1ps

package afd_pkg;

   localparam int DEFAULT_WINDOW = 64;
   localparam int SAMPLE_W       = 16;
   localparam int NUM_CHAN       = 3;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int GAIN_W         = 4;
   localparam int VOTES_W        = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_THR_RED   = 3'd0,
      CSR_MIN_THR_BLUE  = 3'd1,
      CSR_MIN_THR_WHITE = 3'd2,
      CSR_THR_CAP       = 3'd3,
      CSR_MEAN_GAIN     = 3'd4,
      CSR_SENSITIVITY   = 3'd5,
      CSR_VOTES_NEEDED  = 3'd6
   } csr_index_type;

   localparam logic [SAMPLE_W-1:0] RST_MIN_THR_RED   = 16'd40;
   localparam logic [SAMPLE_W-1:0] RST_MIN_THR_BLUE  = 16'd20;
   localparam logic [SAMPLE_W-1:0] RST_MIN_THR_WHITE = 16'd40;
   localparam logic [SAMPLE_W-1:0] RST_THR_CAP       = 16'd80;
   localparam logic [GAIN_W-1:0]   RST_MEAN_GAIN     = 4'd5;
   localparam logic [SAMPLE_W-1:0] RST_SENSITIVITY   = 16'd0;
   localparam logic [VOTES_W-1:0]  RST_VOTES_NEEDED  = 2'd2;

   localparam logic [SAMPLE_W-1:0] EDGE_COUNT_MAX = 16'hFFFF;

endpackage

[rtl/adaptive_flicker_detector_unit.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata: red, blue, white samples (16 b each)
// rsp      out        rsp_tvalid/tready    tdata: led_on, channel_on_bits, zero pad
// csr      in         csr_we               csr_index, csr_wdata (write only)
//
// One item per cycle sustained unless the output stalls; a result is offered once its item
// has passed: difference + window read, running-sum update, decision + output register.
// The window memory has one write and one registered read port; the pointer
// advances each item so the read never hits the entry being written.
// The first item after reset only primes the previous sample and gives no result.
// Reset is synchronous; the window memory is not cleared, entries are used only once written.
// A stalled output holds its result while the two inner stages keep filling.

module adaptive_flicker_detector_unit #(
   parameter int WINDOW = afd_pkg::DEFAULT_WINDOW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [3*afd_pkg::SAMPLE_W-1:0]      req_tdata,  // red, blue, white
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // led_on, channel_on_bits[2:0], pad
   input  logic                                csr_we,
   input  logic [afd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [afd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SW     = afd_pkg::SAMPLE_W;
   localparam int NC     = afd_pkg::NUM_CHAN;
   localparam int ROW_W  = NC * SW;
   localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = SW + $clog2(WINDOW);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_END = FILL_W'(WINDOW);

   // configuration
   logic [SW-1:0]                  min_thr_ff [NC];
   logic [SW-1:0]                  thr_cap_ff;
   logic [afd_pkg::GAIN_W-1:0]     mean_gain_ff;
   logic [SW-1:0]                  sensitivity_ff;
   logic [afd_pkg::VOTES_W-1:0]    votes_needed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_thr_ff[0]   <= afd_pkg::RST_MIN_THR_RED;
         min_thr_ff[1]   <= afd_pkg::RST_MIN_THR_BLUE;
         min_thr_ff[2]   <= afd_pkg::RST_MIN_THR_WHITE;
         thr_cap_ff      <= afd_pkg::RST_THR_CAP;
         mean_gain_ff    <= afd_pkg::RST_MEAN_GAIN;
         sensitivity_ff  <= afd_pkg::RST_SENSITIVITY;
         votes_needed_ff <= afd_pkg::RST_VOTES_NEEDED;
      end else if (csr_we) begin
         case (csr_index)
            afd_pkg::CSR_MIN_THR_RED:   min_thr_ff[0]   <= csr_wdata;
            afd_pkg::CSR_MIN_THR_BLUE:  min_thr_ff[1]   <= csr_wdata;
            afd_pkg::CSR_MIN_THR_WHITE: min_thr_ff[2]   <= csr_wdata;
            afd_pkg::CSR_THR_CAP:       thr_cap_ff      <= csr_wdata;
            afd_pkg::CSR_MEAN_GAIN:     mean_gain_ff    <= csr_wdata[afd_pkg::GAIN_W-1:0];
            afd_pkg::CSR_SENSITIVITY:   sensitivity_ff  <= csr_wdata;
            afd_pkg::CSR_VOTES_NEEDED:  votes_needed_ff <= csr_wdata[afd_pkg::VOTES_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic out_free, b_go, a_go, accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign b_go       = b_valid_ff && out_free;
   assign a_go       = a_valid_ff && (!b_valid_ff || b_go);
   assign req_tready = !a_valid_ff || a_go;
   assign accept     = req_tvalid && req_tready;

   // stage A: difference, window read
   logic [ROW_W-1:0]  win_mem [WINDOW];
   logic [ROW_W-1:0]  old_row_ff;
   logic [ROW_W-1:0]  prev_ff;
   logic              primed_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ROW_W-1:0]  diff_in, a_diff_ff;
   logic [PTR_W-1:0]  a_pos_ff;
   logic [FILL_W-1:0] a_fill_ff;
   logic              a_sub_ff;
   logic              full;

   assign full    = (fill_ff == FILL_END);
   assign fill_in = full ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         if (req_tdata[c*SW +: SW] >= prev_ff[c*SW +: SW]) begin
            diff_in[c*SW +: SW] = req_tdata[c*SW +: SW] - prev_ff[c*SW +: SW];
         end else begin
            diff_in[c*SW +: SW] = prev_ff[c*SW +: SW] - req_tdata[c*SW +: SW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         primed_ff <= 1'b0;
         ptr_ff    <= '0;
         fill_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= (accept && primed_ff) || (a_valid_ff && !a_go);
         if (accept) begin
            prev_ff   <= req_tdata;
            primed_ff <= 1'b1;
            if (primed_ff) begin
               fill_ff    <= fill_in;
               ptr_ff     <= (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && primed_ff) begin
         a_diff_ff  <= diff_in;
         a_pos_ff   <= ptr_ff;
         a_fill_ff  <= fill_in;
         a_sub_ff   <= full;
         old_row_ff <= win_mem[ptr_ff];
      end
      if (a_go) begin
         win_mem[a_pos_ff] <= a_diff_ff;
      end
   end

   // stage B: running sums
   logic [SUM_W-1:0]  sum_ff [NC];
   logic [SUM_W-1:0]  sum_in [NC];
   logic [ROW_W-1:0]  b_diff_ff;
   logic [FILL_W-1:0] b_fill_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         sum_in[c] = sum_ff[c] + SUM_W'(a_diff_ff[c*SW +: SW])
                     - (a_sub_ff ? SUM_W'(old_row_ff[c*SW +: SW]) : SUM_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         b_valid_ff <= a_go || (b_valid_ff && !b_go);
         if (a_go) begin
            for (int c = 0; c < NC; c++) begin
               sum_ff[c] <= sum_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         b_diff_ff <= a_diff_ff;
         b_fill_ff <= a_fill_ff;
      end
   end

   // stage C: per-channel decision and output register
   logic [NC-1:0]              on_next;
   logic [afd_pkg::VOTES_W-1:0] votes;
   logic                       led_in;
   logic [NC-1:0]              rsp_bits_ff;
   logic                       rsp_led_ff;

   for (genvar g = 0; g < NC; g++) begin : g_chan
      afd_chan #(.WINDOW(WINDOW)) u_chan (
         .clock     (clock),
         .reset     (reset),
         .step      (b_go),
         .diff      (b_diff_ff[g*SW +: SW]),
         .sum       (sum_ff[g]),
         .fill      (b_fill_ff),
         .floor_thr (min_thr_ff[g]),
         .cap_thr   (thr_cap_ff),
         .gain      (mean_gain_ff),
         .sens      (sensitivity_ff),
         .on_next   (on_next[g])
      );
   end

   assign votes  = afd_pkg::VOTES_W'($countones(on_next));
   assign led_in = (votes >= votes_needed_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         rsp_led_ff  <= led_in;
         rsp_bits_ff <= on_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_bits_ff, rsp_led_ff};

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_END)
      else $error("window fill count beyond window length");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_LAST)
      else $error("window pointer beyond last entry");

   a_unprimed_empty: assert property (@(posedge clock) disable iff (reset)
      !primed_ff |-> (!a_valid_ff && !b_valid_ff))
      else $error("item in flight before priming sample");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_valid_ff))
      else $error("result raised without an item in the sum stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && b_valid_ff) |=> b_valid_ff)
      else $error("sum stage item lost under output stall");

endmodule

[rtl/afd_chan.sv]
`timescale 1ns / 1ps

module afd_chan #(
   parameter int WINDOW = afd_pkg::DEFAULT_WINDOW,
   localparam int SUM_W  = afd_pkg::SAMPLE_W + $clog2(WINDOW),
   localparam int FILL_W = $clog2(WINDOW + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [afd_pkg::SAMPLE_W-1:0]         diff,
   input  logic [SUM_W-1:0]                     sum,
   input  logic [FILL_W-1:0]                    fill,
   input  logic [afd_pkg::SAMPLE_W-1:0]         floor_thr,
   input  logic [afd_pkg::SAMPLE_W-1:0]         cap_thr,
   input  logic [afd_pkg::GAIN_W-1:0]           gain,
   input  logic [afd_pkg::SAMPLE_W-1:0]         sens,
   output logic                                 on_next
);

   localparam int LHS_W = afd_pkg::SAMPLE_W + FILL_W;
   localparam int RHS_W = SUM_W + afd_pkg::GAIN_W;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
   localparam int HOLD_W = $clog2(WINDOW + 1);
   localparam logic [HOLD_W-1:0] HOLD_END = HOLD_W'(WINDOW);

   logic                         armed_ff, armed_in;
   logic                         on_ff, on_in;
   logic [HOLD_W-1:0]            hold_ff, hold_in;
   logic [afd_pkg::SAMPLE_W-1:0] edge_ff, edge_in;

   logic [CMP_W-1:0]             lhs, rhs;
   logic                         above;
   logic [HOLD_W-1:0]            hold_mid;

   // exact mean compare: d > S*g/L  <=>  d*L > S*g
   assign lhs   = CMP_W'(diff) * CMP_W'(fill);
   assign rhs   = CMP_W'(sum) * CMP_W'(gain);
   assign above = ((diff > floor_thr) && (lhs > rhs)) || (diff > cap_thr);

   always_comb begin
      armed_in = armed_ff;
      on_in    = on_ff;
      hold_mid = hold_ff;
      edge_in  = edge_ff;
      if (above) begin
         if (!armed_ff) begin
            hold_mid = '0;
            if (edge_ff != afd_pkg::EDGE_COUNT_MAX) begin
               edge_in = edge_ff + 1'b1;
            end
            armed_in = 1'b1;
         end
      end else if (diff < floor_thr) begin
         armed_in = 1'b0;
      end
      if ((hold_mid < HOLD_END) && (edge_in > sens)) begin
         on_in = 1'b1;
      end else if (hold_mid >= HOLD_END) begin
         on_in   = 1'b0;
         edge_in = '0;
      end
      hold_in = (hold_mid < HOLD_END) ? hold_mid + 1'b1 : hold_mid;
   end

   assign on_next = on_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         on_ff    <= 1'b0;
         hold_ff  <= '0;
         edge_ff  <= '0;
      end else if (step) begin
         armed_ff <= armed_in;
         on_ff    <= on_in;
         hold_ff  <= hold_in;
         edge_ff  <= edge_in;
      end
   end

endmodule
